@@ rtl/sth_pkg.sv @@
//------------------------------------------------------------------------------
// sth_pkg
// Shared types and constants for the segment/triangle hit test.
//------------------------------------------------------------------------------
`default_nettype none
package sth_pkg;
    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CfgStartX = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgStartY = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgStartZ = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgEndX   = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgEndY   = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgEndZ   = 3'd5;
    localparam logic signed [33:0] OneQ = 34'sd65536;

    // Microcode ops for the shared unit
    typedef enum logic [2:0] {
        OP_SUB,   // dst = sat(a - b)
        OP_MUL,   // acc = floor(a*b>>16)
        OP_MAC,   // acc += floor(a*b>>16)
        OP_MSB,   // acc -= floor(a*b>>16)
        OP_SAT,   // dst = sat(acc)
        OP_SGN    // flag from acc sign
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SETUP, ST_DIV, ST_INSIDE, ST_OUT
    } t_state;

    // status from datapath to sequencer
    typedef struct packed {
        logic acc_pos;
    } t_alu_flags;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] mx;
        logic signed [65:0] mn;
        mx = 66'sd2147483647;
        mn = -66'sd2147483648;
        if (v > mx) return 32'sh7fffffff;
        if (v < mn) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

@@ rtl/sth_alu.sv @@
//------------------------------------------------------------------------------
// sth_alu
// Shared Q16.16 unit: saturating subtract, floored multiply into a wide
// accumulator, and accumulator saturation.
//------------------------------------------------------------------------------
`default_nettype none
module sth_alu (
    input  wire logic              i_clk,
    input  wire sth_pkg::t_op      i_op,
    input  wire logic              i_en,
    input  wire logic signed [33:0] i_a,
    input  wire logic signed [33:0] i_b,
    output logic signed [31:0]     o_res,
    output sth_pkg::t_alu_flags    o_flags
);
    import sth_pkg::*;
    logic signed [67:0] r_acc;
    logic signed [67:0] n_acc;
    logic signed [67:0] w_prod;
    logic signed [65:0] w_diff;

    assign w_prod = (i_a * i_b) >>> 16;
    assign w_diff = 66'(i_a) - 66'(i_b);

    always_comb begin
        n_acc = r_acc;
        o_res = sat32(w_diff);
        unique case (i_op)
            OP_MUL: n_acc = w_prod;
            OP_MAC: n_acc = r_acc + w_prod;
            OP_MSB: n_acc = r_acc - w_prod;
            OP_SAT: o_res = sat32(r_acc[65:0]);
            default: ;
        endcase
        if (i_op == OP_SAT && (r_acc > 68'sd2147483647)) o_res = 32'sh7fffffff;
        if (i_op == OP_SAT && (r_acc < -68'sd2147483648)) o_res = 32'sh80000000;
    end

    assign o_flags.acc_pos = (r_acc > 0);

    always_ff @(posedge i_clk) begin
        if (i_en) r_acc <= n_acc;
    end
endmodule
`default_nettype wire

@@ rtl/sth_div.sv @@
//------------------------------------------------------------------------------
// sth_div
// Restoring divider, one quotient bit per cycle: q = floor(n*2^16/d).
//------------------------------------------------------------------------------
`default_nettype none
module sth_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [32:0] i_den,
    output logic             o_done,
    output logic [16:0]      o_quo
);
    logic [48:0] r_num;
    logic [33:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] r_den;
    logic [33:0] w_sh;

    assign w_sh = {r_rem[32:0], r_num[48]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= {1'b0, i_num, 16'd0};
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= 6'd49;
            end else if (r_busy) begin
                r_num <= {r_num[47:0], 1'b0};
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= w_sh - {1'b0, r_den};
                    o_quo <= {o_quo[15:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    o_quo <= {o_quo[15:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/segment_triangle_hit_test_unit.sv @@
//------------------------------------------------------------------------------
// segment_triangle_hit_test_unit
// One-sided segment versus triangle hit test, Q16.16, with sticky model hit.
//------------------------------------------------------------------------------
// One triangle is worked at a time through a microcoded sequencer that drives
// a single 34x34 multiply/accumulate/subtract unit, one step per cycle, plus a
// bit-serial 49-step divider for the crossing ratio. A miss on the plane test
// runs the 29 setup steps and then one output step; a candidate runs the 29
// setup steps, the divider with its start and done, the 62 point and inside
// steps and one output step. Input stall is high while an item is in work.
// A finished result waits in the output register and the next item may start
// behind it; the sequencer holds in its output step until that register is
// free.
`default_nettype none
module segment_triangle_hit_test_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic signed [31:0] i_a_x, input wire logic signed [31:0] i_a_y,
    input  wire logic signed [31:0] i_a_z, input wire logic signed [31:0] i_b_x,
    input  wire logic signed [31:0] i_b_y, input wire logic signed [31:0] i_b_z,
    input  wire logic signed [31:0] i_c_x, input wire logic signed [31:0] i_c_y,
    input  wire logic signed [31:0] i_c_z,
    input  wire logic        i_final_tri,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_tri_hit,
    output logic             o_model_hit,
    output logic             o_final_out
);
    import sth_pkg::*;

    // register file slots; temporaries share slots where lifetimes do not overlap
    localparam int RF = 32;
    typedef logic [4:0] t_reg;
    localparam t_reg AX = 5'd0, AY = 5'd1, AZ = 5'd2;
    localparam t_reg BX = 5'd3, BY = 5'd4, BZ = 5'd5;
    localparam t_reg CX = 5'd6, CY = 5'd7, CZ = 5'd8;
    localparam t_reg SX = 5'd9, SY = 5'd10, SZ = 5'd11;
    localparam t_reg EX = 5'd12, EY = 5'd13, EZ = 5'd14;
    localparam t_reg E1X = 5'd15, E1Y = 5'd16, E1Z = 5'd17;
    localparam t_reg VAX = 5'd15, VAY = 5'd16, VAZ = 5'd17;
    localparam t_reg UX = 5'd15, UY = 5'd16, UZ = 5'd17;
    localparam t_reg E2X = 5'd18, E2Y = 5'd19, E2Z = 5'd20;
    localparam t_reg VBX = 5'd18, VBY = 5'd19, VBZ = 5'd20;
    localparam t_reg WX = 5'd18, WY = 5'd19, WZ = 5'd20;
    localparam t_reg NX = 5'd21, NY = 5'd22, NZ = 5'd23;
    localparam t_reg K1X = 5'd21, K1Y = 5'd22, K1Z = 5'd23;
    localparam t_reg K2X = 5'd24, K2Y = 5'd25, K2Z = 5'd26;
    localparam t_reg K3X = 5'd24, K3Y = 5'd25, K3Z = 5'd26;
    localparam t_reg PX = 5'd27, PY = 5'd28, PZ = 5'd29;
    localparam t_reg D1 = 5'd30, TQ = 5'd30;
    localparam t_reg D2 = 5'd31, OMT = 5'd31;
    // operand slot for steps that ignore it
    localparam t_reg ZR = 5'd0;

    typedef struct packed {
        t_op  op;
        t_reg a;
        t_reg b;
        t_reg d;
    } t_uop;

    logic signed [31:0] r_rf [RF];
    t_state r_state, n_state;
    logic [7:0] r_pc, n_pc;
    logic r_fin, r_tri, r_hsf, r_ov, r_ot, r_om, r_of, r_k12;
    logic r_dstart;
    t_uop w_u;
    logic signed [31:0] w_res;
    t_alu_flags w_fl;
    logic w_en, w_wr, w_ddone;
    logic [16:0] w_quo;
    logic signed [33:0] w_a, w_b;
    logic [7:0] w_len;

    function automatic t_uop mk(t_op o, t_reg a, t_reg b, t_reg d);
        mk.op = o; mk.a = a; mk.b = b; mk.d = d;
    endfunction

    // setup program: edges, normal, d1, d2
    function automatic t_uop setup_rom(logic [7:0] pc);
        unique case (pc)
            8'd0:  return mk(OP_SUB, BX, AX, E1X);
            8'd1:  return mk(OP_SUB, BY, AY, E1Y);
            8'd2:  return mk(OP_SUB, BZ, AZ, E1Z);
            8'd3:  return mk(OP_SUB, CX, AX, E2X);
            8'd4:  return mk(OP_SUB, CY, AY, E2Y);
            8'd5:  return mk(OP_SUB, CZ, AZ, E2Z);
            8'd6:  return mk(OP_MUL, E2Y, E1Z, ZR);
            8'd7:  return mk(OP_MSB, E2Z, E1Y, ZR);
            8'd8:  return mk(OP_SAT, ZR, ZR, NX);
            8'd9:  return mk(OP_MUL, E2Z, E1X, ZR);
            8'd10: return mk(OP_MSB, E2X, E1Z, ZR);
            8'd11: return mk(OP_SAT, ZR, ZR, NY);
            8'd12: return mk(OP_MUL, E2X, E1Y, ZR);
            8'd13: return mk(OP_MSB, E2Y, E1X, ZR);
            8'd14: return mk(OP_SAT, ZR, ZR, NZ);
            8'd15: return mk(OP_SUB, AX, SX, VAX);
            8'd16: return mk(OP_SUB, AY, SY, VAY);
            8'd17: return mk(OP_SUB, AZ, SZ, VAZ);
            8'd18: return mk(OP_SUB, AX, EX, VBX);
            8'd19: return mk(OP_SUB, AY, EY, VBY);
            8'd20: return mk(OP_SUB, AZ, EZ, VBZ);
            8'd21: return mk(OP_MUL, VAX, NX, ZR);
            8'd22: return mk(OP_MAC, VAY, NY, ZR);
            8'd23: return mk(OP_MAC, VAZ, NZ, ZR);
            8'd24: return mk(OP_SAT, ZR, ZR, D1);
            8'd25: return mk(OP_MUL, VBX, NX, ZR);
            8'd26: return mk(OP_MAC, VBY, NY, ZR);
            8'd27: return mk(OP_MAC, VBZ, NZ, ZR);
            default: return mk(OP_SAT, ZR, ZR, D2);
        endcase
    endfunction

    // cross (u x w) into k, 9 steps
    function automatic t_uop cross_step(logic [3:0] s, t_reg kx, t_reg ky, t_reg kz);
        unique case (s)
            4'd0: return mk(OP_MUL, UY, WZ, ZR);
            4'd1: return mk(OP_MSB, UZ, WY, ZR);
            4'd2: return mk(OP_SAT, ZR, ZR, kx);
            4'd3: return mk(OP_MUL, UZ, WX, ZR);
            4'd4: return mk(OP_MSB, UX, WZ, ZR);
            4'd5: return mk(OP_SAT, ZR, ZR, ky);
            4'd6: return mk(OP_MUL, UX, WY, ZR);
            4'd7: return mk(OP_MSB, UY, WX, ZR);
            default: return mk(OP_SAT, ZR, ZR, kz);
        endcase
    endfunction

    // point and inside program; k3 overwrites k2 once k1.k2 is taken
    function automatic t_uop inside_rom(logic [7:0] pc);
        unique case (pc)
            8'd0: return mk(OP_MUL, SX, OMT, ZR);
            8'd1: return mk(OP_MAC, EX, TQ, ZR);
            8'd2: return mk(OP_SAT, ZR, ZR, PX);
            8'd3: return mk(OP_MUL, SY, OMT, ZR);
            8'd4: return mk(OP_MAC, EY, TQ, ZR);
            8'd5: return mk(OP_SAT, ZR, ZR, PY);
            8'd6: return mk(OP_MUL, SZ, OMT, ZR);
            8'd7: return mk(OP_MAC, EZ, TQ, ZR);
            8'd8: return mk(OP_SAT, ZR, ZR, PZ);
            8'd9:  return mk(OP_SUB, PX, AX, UX);
            8'd10: return mk(OP_SUB, PY, AY, UY);
            8'd11: return mk(OP_SUB, PZ, AZ, UZ);
            8'd12: return mk(OP_SUB, BX, AX, WX);
            8'd13: return mk(OP_SUB, BY, AY, WY);
            8'd14: return mk(OP_SUB, BZ, AZ, WZ);
            8'd24: return mk(OP_SUB, PX, BX, UX);
            8'd25: return mk(OP_SUB, PY, BY, UY);
            8'd26: return mk(OP_SUB, PZ, BZ, UZ);
            8'd27: return mk(OP_SUB, CX, BX, WX);
            8'd28: return mk(OP_SUB, CY, BY, WY);
            8'd29: return mk(OP_SUB, CZ, BZ, WZ);
            8'd39: return mk(OP_MUL, K1X, K2X, ZR);
            8'd40: return mk(OP_MAC, K1Y, K2Y, ZR);
            8'd41: return mk(OP_MAC, K1Z, K2Z, ZR);
            8'd42: return mk(OP_SGN, ZR, ZR, ZR);
            8'd43: return mk(OP_SUB, PX, CX, UX);
            8'd44: return mk(OP_SUB, PY, CY, UY);
            8'd45: return mk(OP_SUB, PZ, CZ, UZ);
            8'd46: return mk(OP_SUB, AX, CX, WX);
            8'd47: return mk(OP_SUB, AY, CY, WY);
            8'd48: return mk(OP_SUB, AZ, CZ, WZ);
            8'd58: return mk(OP_MUL, K1X, K3X, ZR);
            8'd59: return mk(OP_MAC, K1Y, K3Y, ZR);
            8'd60: return mk(OP_MAC, K1Z, K3Z, ZR);
            8'd61: return mk(OP_SGN, ZR, ZR, ZR);
            default: begin
                if (pc >= 8'd15 && pc < 8'd24)
                    return cross_step(4'(pc - 8'd15), K1X, K1Y, K1Z);
                if (pc >= 8'd30 && pc < 8'd39)
                    return cross_step(4'(pc - 8'd30), K2X, K2Y, K2Z);
                return cross_step(4'(pc - 8'd49), K3X, K3Y, K3Z);
            end
        endcase
    endfunction

    always_comb begin
        w_u = mk(OP_SGN, ZR, ZR, ZR);
        w_len = 8'd0;
        if (r_state == ST_SETUP) begin
            w_u = setup_rom(r_pc); w_len = 8'd28;
        end else if (r_state == ST_INSIDE) begin
            w_u = inside_rom(r_pc); w_len = 8'd61;
        end
    end

    // TQ and OMT are unsigned up to 2^16: widen with zero so 1.0 fits
    always_comb begin
        w_a = 34'(r_rf[w_u.a]);
        w_b = 34'(r_rf[w_u.b]);
        if (w_u.b == TQ || w_u.b == OMT) w_b = {2'b00, r_rf[w_u.b]};
    end

    assign w_en = (r_state == ST_SETUP) || (r_state == ST_INSIDE);
    assign w_wr = w_en && (w_u.op == OP_SUB || w_u.op == OP_SAT);

    sth_alu u_alu (
        .i_clk(i_clk), .i_op(w_u.op), .i_en(w_en),
        .i_a(w_a), .i_b(w_b), .o_res(w_res), .o_flags(w_fl)
    );

    sth_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(32'(-r_rf[D1])),
        .i_den(33'(-34'(r_rf[D1])) + 33'(r_rf[D2])),
        .o_done(w_ddone), .o_quo(w_quo)
    );

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_ov;
    assign o_tri_hit = r_ot;
    assign o_model_hit = r_om;
    assign o_final_out = r_of;

    always_comb begin
        n_state = r_state;
        n_pc = r_pc;
        unique case (r_state)
            ST_IDLE: if (i_valid && !o_stall) begin
                n_state = ST_SETUP; n_pc = '0;
            end
            ST_SETUP: begin
                n_pc = r_pc + 8'd1;
                if (r_pc == w_len) begin
                    n_pc = '0;
                    // d2 is being written this cycle from the accumulator
                    if (r_rf[D1][31] && w_fl.acc_pos) n_state = ST_DIV;
                    else n_state = ST_OUT;
                end
            end
            ST_DIV: if (w_ddone) begin
                n_state = ST_INSIDE; n_pc = '0;
            end
            ST_INSIDE: begin
                n_pc = r_pc + 8'd1;
                if (r_pc == w_len) n_state = ST_OUT;
            end
            ST_OUT: if (!r_ov || !i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc <= '0;
            r_ov <= 1'b0;
            r_hsf <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc <= n_pc;
            r_dstart <= (r_state == ST_SETUP) && (n_state == ST_DIV);
            if (r_state == ST_OUT && (!r_ov || !i_stall)) begin
                r_ov <= 1'b1;
                r_ot <= r_tri;
                r_om <= r_hsf | r_tri;
                r_of <= r_fin;
                r_hsf <= r_fin ? 1'b0 : (r_hsf | r_tri);
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf[SX] <= '0; r_rf[SY] <= '0; r_rf[SZ] <= '0;
            r_rf[EX] <= '0; r_rf[EY] <= '0; r_rf[EZ] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgStartX: r_rf[SX] <= i_cfg_data;
                CfgStartY: r_rf[SY] <= i_cfg_data;
                CfgStartZ: r_rf[SZ] <= i_cfg_data;
                CfgEndX:   r_rf[EX] <= i_cfg_data;
                CfgEndY:   r_rf[EY] <= i_cfg_data;
                CfgEndZ:   r_rf[EZ] <= i_cfg_data;
                default: ;
            endcase
        end
        if (r_state == ST_IDLE && i_valid && !o_stall) begin
            r_rf[AX] <= i_a_x; r_rf[AY] <= i_a_y; r_rf[AZ] <= i_a_z;
            r_rf[BX] <= i_b_x; r_rf[BY] <= i_b_y; r_rf[BZ] <= i_b_z;
            r_rf[CX] <= i_c_x; r_rf[CY] <= i_c_y; r_rf[CZ] <= i_c_z;
            r_fin <= i_final_tri;
            r_tri <= 1'b0;
        end
        if (w_wr) r_rf[w_u.d] <= w_res;
        if (w_ddone) begin
            r_rf[TQ]  <= 32'(w_quo);
            r_rf[OMT] <= 32'(OneQ - 34'(w_quo));
        end
        if (r_state == ST_INSIDE && w_u.op == OP_SGN) begin
            if (r_pc == 8'd42) r_k12 <= w_fl.acc_pos;
            else r_tri <= r_k12 & w_fl.acc_pos;
        end
    end

`ifndef SYNTH
    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall) else $error("accept while busy");
    a_div_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && $past(r_state) != ST_OUT && r_tri)
        |-> $past(r_state) == ST_INSIDE)
        else $error("hit without inside test");
`endif
endmodule
`default_nettype wire

@@ test/tb.sv @@
//------------------------------------------------------------------------------
// tb
// Checks the segment/triangle hit test unit. Directed triangles cover the
// degenerate, on-plane, wrong-way and on-edge cases and the coordinate
// extremes. Random triangles are then placed around the segment, mixed with
// full-range noise. A fixed-point model predicts every result.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
    import sth_pkg::*;

    typedef logic signed [31:0] t_coord;
    typedef longint t_vec3[3];
    typedef struct {
        t_coord v[3][3];   // vertex a, b, c; component x, y, z
        bit     fin;
    } t_tri_item;
    typedef struct {
        bit tri_hit;
        bit model_hit;
        bit fin;
    } t_hit_result;

    localparam longint OneQ16 = 65536;
    localparam int Unit = 65536;

    class t_hit_scoreboard;
        longint      seg_s[3];
        longint      seg_e[3];
        bit          hit_so_far;
        t_hit_result pending[$];
        int          errors;

        function void clear();
            foreach (seg_s[i]) begin
                seg_s[i] = 0;
                seg_e[i] = 0;
            end
            hit_so_far = 0;
        endfunction

        function void set_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
            longint v;
            v = longint'(signed'(data));
            case (idx)
                CfgStartX: seg_s[0] = v;
                CfgStartY: seg_s[1] = v;
                CfgStartZ: seg_s[2] = v;
                CfgEndX:   seg_e[0] = v;
                CfgEndY:   seg_e[1] = v;
                CfgEndZ:   seg_e[2] = v;
                default: ;
            endcase
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint mulq(longint x, longint y);
            return (x * y) >>> 16;
        endfunction

        function void vsub(input t_vec3 p, input t_vec3 q, output t_vec3 r);
            foreach (r[i]) r[i] = sat(p[i] - q[i]);
        endfunction

        function void vcross(input t_vec3 u, input t_vec3 w, output t_vec3 r);
            r[0] = sat(mulq(u[1], w[2]) - mulq(u[2], w[1]));
            r[1] = sat(mulq(u[2], w[0]) - mulq(u[0], w[2]));
            r[2] = sat(mulq(u[0], w[1]) - mulq(u[1], w[0]));
        endfunction

        function longint vdot(t_vec3 u, t_vec3 w);
            return mulq(u[0], w[0]) + mulq(u[1], w[1]) + mulq(u[2], w[2]);
        endfunction

        function bit crosses(t_tri_item t);
            t_vec3 a, b, c, e1, e2, n, va, vb, p, u, w, k1, k2, k3;
            longint d1, d2, ratio;
            foreach (a[i]) begin
                a[i] = t.v[0][i];
                b[i] = t.v[1][i];
                c[i] = t.v[2][i];
            end
            vsub(b, a, e1);
            vsub(c, a, e2);
            vcross(e2, e1, n);
            vsub(a, seg_s, va);
            vsub(a, seg_e, vb);
            d1 = sat(vdot(va, n));
            d2 = sat(vdot(vb, n));
            // one-sided: start behind the plane, end in front
            if (!(d1 < 0 && d2 > 0)) return 0;
            ratio = (-d1 * OneQ16) / (-d1 + d2);
            foreach (p[i]) p[i] = sat(mulq(seg_s[i], OneQ16 - ratio) + mulq(seg_e[i], ratio));
            vsub(p, a, u); vsub(b, a, w); vcross(u, w, k1);
            vsub(p, b, u); vsub(c, b, w); vcross(u, w, k2);
            vsub(p, c, u); vsub(a, c, w); vcross(u, w, k3);
            return vdot(k1, k2) > 0 && vdot(k1, k3) > 0;
        endfunction

        function void note_triangle(t_tri_item t);
            t_hit_result r;
            r.tri_hit = crosses(t);
            r.model_hit = hit_so_far | r.tri_hit;
            r.fin = t.fin;
            hit_so_far = t.fin ? 1'b0 : r.model_hit;
            pending = {pending, r};
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(bit tri_hit, bit model_hit, bit fin);
            t_hit_result r;
            if (pending.size() == 0) begin
                report("result with no triangle outstanding");
                return;
            end
            r = pending.pop_front();
            if (tri_hit !== r.tri_hit)
                report($sformatf("tri_hit %b, expected %b", tri_hit, r.tri_hit));
            if (model_hit !== r.model_hit)
                report($sformatf("model_hit %b, expected %b", model_hit, r.model_hit));
            if (fin !== r.fin)
                report($sformatf("final_out %b, expected %b", fin, r.fin));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [31:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z;
    logic               i_final_tri;
    logic               o_valid;
    logic               i_stall;
    logic               o_tri_hit, o_model_hit, o_final_out;

    t_hit_scoreboard sb = new;
    bit              quiet_out;
    int              stall_left;

    segment_triangle_hit_test_unit uut (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("FAILURE");
        $finish;
    end

    // receiver stalls: mostly short bursts, sometimes long, none while quiet
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet_out) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else begin
            int r;
            r = $urandom_range(99);
            if (r < 60) begin
                i_stall <= 1'b0;
            end else if (r < 95) begin
                i_stall <= 1'b1;
                stall_left = $urandom_range(2);
            end else begin
                i_stall <= 1'b1;
                stall_left = $urandom_range(80, 20);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_tri_hit, o_model_hit, o_final_out);
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_segment(longint sx, longint sy, longint sz,
                               longint ex, longint ey, longint ez);
        cfg_write(CfgStartX, sx[31:0]);
        cfg_write(CfgStartY, sy[31:0]);
        cfg_write(CfgStartZ, sz[31:0]);
        cfg_write(CfgEndX, ex[31:0]);
        cfg_write(CfgEndY, ey[31:0]);
        cfg_write(CfgEndZ, ez[31:0]);
        // unused indexes must be ignored
        cfg_write(3'($urandom_range(7, 6)), $urandom);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic send_tri(t_tri_item t, bit gaps);
        int gap;
        int r;
        gap = 0;
        if (gaps) begin
            r = $urandom_range(99);
            if (r >= 70 && r < 95) gap = $urandom_range(3, 1);
            else if (r >= 95) gap = $urandom_range(60, 10);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_a_x, i_a_y, i_a_z} <= {t.v[0][0], t.v[0][1], t.v[0][2]};
        {i_b_x, i_b_y, i_b_z} <= {t.v[1][0], t.v[1][1], t.v[1][2]};
        {i_c_x, i_c_y, i_c_z} <= {t.v[2][0], t.v[2][1], t.v[2][2]};
        i_final_tri <= t.fin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_triangle(t);
    endtask

    function automatic t_tri_item make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                           int cx, int cy, int cz, bit fin);
        t_tri_item t;
        t.v[0] = '{ax, ay, az};
        t.v[1] = '{bx, by, bz};
        t.v[2] = '{cx, cy, cz};
        t.fin = fin;
        return t;
    endfunction

    // triangle scattered around the segment midpoint, offsets kept small
    function automatic t_tri_item near_segment();
        t_tri_item t;
        foreach (t.v[k, i])
            t.v[k][i] = t_coord'((sb.seg_s[i] + sb.seg_e[i]) / 2
                        + $signed($urandom_range(12 * Unit)) - 6 * Unit);
        t.fin = ($urandom_range(7) == 0);
        return t;
    endfunction

    function automatic t_tri_item noise_tri();
        t_tri_item t;
        foreach (t.v[k, i]) t.v[k][i] = $urandom;
        t.fin = $urandom_range(1);
        return t;
    endfunction

    task automatic random_phase(int count, bit gaps);
        t_tri_item t;
        repeat (count) begin
            t = ($urandom_range(99) < 80) ? near_segment() : noise_tri();
            send_tri(t, gaps);
        end
        i_valid <= 1'b0;
        drain();
    endtask

    function automatic longint rnd_coord();
        return $signed($urandom_range(16 * Unit)) - 8 * Unit;
    endfunction

    initial begin
        int u;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        {i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z} = '0;
        i_final_tri = 1'b0;
        quiet_out = 1'b0;
        sb.clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset segment is a single point at the origin
        send_tri(make_tri(-Unit, -Unit, 0, Unit, -Unit, 0, 0, Unit, 0, 1), 0);
        i_valid <= 1'b0;
        drain();

        u = Unit;
        set_segment(0, 0, -4 * u, 0, 0, 4 * u);
        send_tri(make_tri(-u, -u, 0, u, -u, 0, 0, u, 0, 0), 0);           // one winding
        send_tri(make_tri(-u, -u, 0, 0, u, 0, u, -u, 0, 0), 0);           // other winding
        send_tri(make_tri(u, u, 0, u, u, 0, u, u, 0, 0), 0);              // degenerate
        send_tri(make_tri(-u, -u, 4 * u, u, -u, 4 * u, 0, u, 4 * u, 0), 0); // end on plane
        send_tri(make_tri(-u, -u, 4 * u, 0, u, 4 * u, u, -u, 4 * u, 0), 0);
        send_tri(make_tri(-u, -u, -4 * u, u, -u, -4 * u, 0, u, -4 * u, 1), 0); // start on plane
        send_tri(make_tri(0, -u, 0, 0, u, 0, 2 * u, 0, 0, 0), 0);         // point on edge
        send_tri(make_tri(0, -u, 0, 2 * u, 0, 0, 0, u, 0, 0), 0);
        send_tri(make_tri(0, 0, 0, u, 0, 0, 0, u, 0, 1), 0);              // point on corner
        send_tri(make_tri(0, 0, 0, 0, u, 0, u, 0, 0, 0), 0);
        send_tri(make_tri(5 * u, 5 * u, 0, 7 * u, 5 * u, 0, 6 * u, 7 * u, 0, 1), 0); // miss
        send_tri(make_tri('1 >>> 1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h7fffffff, 0), 0);
        send_tri(make_tri(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                          32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                          32'h80000000, 1), 0);
        send_tri(make_tri(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 0,
                          0, 0, 32'h7fffffff, 0), 0);
        send_tri(make_tri(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7fffffff, 1), 0);
        i_valid <= 1'b0;
        drain();

        // opposite direction: the same triangles should now cross the wrong way
        set_segment(0, 0, 4 * u, 0, 0, -4 * u);
        send_tri(make_tri(-u, -u, 0, u, -u, 0, 0, u, 0, 0), 0);
        send_tri(make_tri(-u, -u, 0, 0, u, 0, u, -u, 0, 1), 0);
        i_valid <= 1'b0;
        drain();

        // random segments, no stalls on the output for the first phase
        quiet_out = 1'b1;
        set_segment(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
        random_phase(200, 0);
        quiet_out = 1'b0;
        repeat (5) begin
            set_segment(rnd_coord(), rnd_coord(), rnd_coord(),
                        rnd_coord(), rnd_coord(), rnd_coord());
            random_phase(230, 1);
        end

        // extreme segment registers
        set_segment(64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff,
                    -64'sh80000000, -64'sh80000000, -64'sh80000000);
        random_phase(50, 1);
        set_segment(-64'sh80000000, 64'sh7fffffff, -64'sh80000000,
                    64'sh7fffffff, -64'sh80000000, 64'sh7fffffff);
        random_phase(50, 1);
        set_segment($signed($urandom), $signed($urandom), $signed($urandom),
                    $signed($urandom), $signed($urandom), $signed($urandom));
        random_phase(50, 1);

        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
